[hw/rtl/thr_rls_pkg.sv]
// Shared constants and types of the thrust model estimator.
package thr_rls_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int QA_W        = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_COMMAND  = 2'd0;
    localparam logic [1:0] OP_ESTIMATE = 2'd1;

    localparam logic [2:0] ST_THROTTLE = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_RECENT   = 3'd3;
    localparam logic [2:0] ST_RESET    = 3'd4;

    localparam logic [2:0] CFG_FORGET  = 3'd0;
    localparam logic [2:0] CFG_GRAVITY = 3'd1;
    localparam logic [2:0] CFG_HOVER   = 3'd2;
    localparam logic [2:0] CFG_WMIN    = 3'd3;
    localparam logic [2:0] CFG_WMAX    = 3'd4;

    localparam logic [16:0] RST_FAC   = 17'd65405;
    localparam logic [19:0] RST_GRAV  = 20'd642908;
    localparam logic [16:0] RST_HOVER = 17'd19661;
    localparam logic [19:0] RST_WMIN  = 20'd35000;
    localparam logic [19:0] RST_WMAX  = 20'd45000;

    localparam logic [31:0] GAIN_INIT = 32'((64'(RST_GRAV) << 16) / 64'(RST_HOVER));
    localparam logic [47:0] COV_INIT  = 48'(64'd1000000 << 24);
    localparam logic [47:0] COV_MAX   = {48{1'b1}};
    localparam logic [19:0] THR_MAX   = 20'h7FFFF;
    localparam logic [19:0] THR_MIN   = 20'h80000;

    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 48;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 80;
    localparam int DIV_D_W = 64;

    localparam logic [6:0] MUL_LAST = 7'(MUL_B_W - 1);
    localparam logic [6:0] DIV_LAST = 7'(DIV_N_W - 1);

    localparam logic [3:0] STEP_CMD  = 4'd0;
    localparam logic [3:0] STEP_SEED = 4'd1;
    localparam logic [3:0] STEP_M1   = 4'd2;
    localparam logic [3:0] STEP_M2   = 4'd3;
    localparam logic [3:0] STEP_M3   = 4'd4;
    localparam logic [3:0] STEP_D1   = 4'd5;
    localparam logic [3:0] STEP_M4   = 4'd6;
    localparam logic [3:0] STEP_M5   = 4'd7;
    localparam logic [3:0] STEP_D2   = 4'd8;
    localparam logic [3:0] STEP_M6   = 4'd9;
    localparam logic [3:0] STEP_D3   = 4'd10;

    typedef struct packed {
        logic [31:0] stamp;
        logic [19:0] thr;
    } t_qentry;

endpackage

[hw/rtl/thrust_model_rls_estimator_unit.sv]
// Thrust model estimator: throttle queue and scalar RLS update on a shared mul/div unit.
// Command: with zero gain a saturated throttle is pushed directly, else the accel magnitude
// is divided by the gain; reset model divides gravity by a nonzero hover; estimate inspects
// queue entries from the head and may run an RLS update (six products, three divisions).
// Items are handled one at a time; the shared multiply/divide unit sets the rate.
// Reset (synchronous, active low) restores state and configuration, empties the queue and seeds the model.
module thrust_model_rls_estimator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,   // accel[31:0], now_us[63:32]
    input  logic [1:0]            s_axis_tuser,   // operation[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [55:0]           m_axis_tdata,   // throttle[19:0], model_gain[51:20], zero
    output logic [2:0]            m_axis_tuser,   // status[2:0]
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [19:0]           i_cfg_data
);
    import thr_rls_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WALK = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_POST = 4'd5;
    localparam logic [3:0] S_OUT  = 4'd6;

    logic [3:0]          r_state, n_state, r_step, n_step;
    logic [16:0]         r_fac, n_fac, r_hover, n_hover;
    logic [19:0]         r_grav, n_grav, r_wmin, n_wmin, r_wmax, n_wmax;
    logic [QA_W-1:0]     r_head, n_head;
    logic [QC_W-1:0]     r_count, n_count;
    logic [31:0]         r_gain, n_gain;
    logic [47:0]         r_cov, n_cov;
    logic [31:0]         r_acc, n_acc, r_now, n_now;
    logic [19:0]         r_at, n_at, r_thr, n_thr;
    logic                r_tneg, n_tneg, r_eneg, n_eneg;
    logic [63:0]         r_d, n_d, r_k, n_k;
    logic [2:0]          r_status, n_status;
    logic [MUL_A_W-1:0]  r_ma, n_ma;
    logic [MUL_B_W-1:0]  r_mb, n_mb;
    logic [MUL_P_W-1:0]  r_mp, n_mp;
    logic [DIV_N_W-1:0]  r_dn, n_dn, r_dq, n_dq;
    logic [DIV_D_W-1:0]  r_dd, n_dd;
    logic [DIV_D_W:0]    r_dr, n_dr;
    logic [6:0]          r_cnt, n_cnt;
    logic                r_ov, n_ov;
    logic [19:0]         r_othr, n_othr;
    logic [2:0]          r_ost, n_ost;
    logic [31:0]         r_ogain, n_ogain;

    t_qentry             r_mem [QUEUE_DEPTH];
    t_qentry             r_mem_q;
    logic                w_we;
    logic [QA_W-1:0]     w_wa;
    t_qentry             w_wd;

    // Datapath temporaries.
    logic                mul_go, div_go, push_en;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [DIV_N_W-1:0]  div_n;
    logic [DIV_D_W-1:0]  div_d;
    logic [19:0]         push_thr;
    logic [31:0]         in_acc, in_mag, age;
    logic [DIV_D_W:0]    div_t;
    logic                div_ge;
    logic [19:0]         qmag;
    logic [37:0]         s_prod, err;
    logic [36:0]         ae_mag;
    logic [87:0]         dlt_raw;
    logic [40:0]         delta;
    logic [42:0]         ng;
    logic [QA_W:0]       slot_sum;
    logic [QA_W-1:0]     head_inc;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'b0, r_ogain, r_othr};
    assign m_axis_tuser  = r_ost;

    assign in_acc   = s_axis_tdata[31:0];
    assign in_mag   = in_acc[31] ? 32'(-in_acc) : in_acc;
    assign age      = r_now - r_mem_q.stamp;
    assign head_inc = (32'(r_head) == QUEUE_DEPTH - 1) ? '0 : r_head + 1'b1;
    assign div_t    = {r_dr[DIV_D_W-1:0], r_dn[DIV_N_W-1]};
    assign div_ge   = div_t >= {1'b0, r_dd};

    always_comb begin
        n_state = r_state;  n_step = r_step;
        n_fac = r_fac;  n_grav = r_grav;  n_hover = r_hover;
        n_wmin = r_wmin;  n_wmax = r_wmax;
        n_head = r_head;  n_count = r_count;
        n_gain = r_gain;  n_cov = r_cov;
        n_acc = r_acc;  n_now = r_now;
        n_at = r_at;  n_thr = r_thr;  n_tneg = r_tneg;  n_eneg = r_eneg;
        n_d = r_d;  n_k = r_k;  n_status = r_status;
        n_ma = r_ma;  n_mb = r_mb;  n_mp = r_mp;
        n_dn = r_dn;  n_dd = r_dd;  n_dr = r_dr;  n_dq = r_dq;  n_cnt = r_cnt;
        n_ov = r_ov && !m_axis_tready;
        n_othr = r_othr;  n_ost = r_ost;  n_ogain = r_ogain;
        mul_go = 1'b0;  mul_a = '0;  mul_b = '0;
        div_go = 1'b0;  div_n = '0;  div_d = '0;
        push_en = 1'b0;  push_thr = '0;
        w_we = 1'b0;  w_wa = '0;  w_wd = '0;
        qmag = '0;  s_prod = '0;  err = '0;  ae_mag = '0;  dlt_raw = '0;  delta = '0;
        ng = '0;
        slot_sum = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FORGET:  n_fac   = i_cfg_data[16:0];
                CFG_GRAVITY: n_grav  = i_cfg_data;
                CFG_HOVER:   n_hover = i_cfg_data[16:0];
                CFG_WMIN:    n_wmin  = i_cfg_data;
                CFG_WMAX:    n_wmax  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_acc = in_acc;
                    n_now = s_axis_tdata[63:32];
                    n_thr = '0;
                    if (s_axis_tuser == OP_COMMAND) begin
                        if (r_gain == '0) begin
                            push_thr = in_acc[31] ? THR_MIN :
                                       ((in_acc != '0) ? THR_MAX : 20'd0);
                            push_en  = 1'b1;
                            n_thr    = push_thr;
                            n_status = ST_THROTTLE;
                            n_state  = S_OUT;
                        end else begin
                            div_go = 1'b1;
                            div_n  = DIV_N_W'({in_mag, 16'b0});
                            div_d  = DIV_D_W'(r_gain);
                            n_step = STEP_CMD;
                        end
                    end else if (s_axis_tuser == OP_ESTIMATE) begin
                        n_state = S_WALK;
                    end else begin
                        n_cov    = COV_INIT;
                        n_status = ST_RESET;
                        if (r_hover == '0) begin
                            n_gain  = '1;
                            n_state = S_OUT;
                        end else begin
                            div_go = 1'b1;
                            div_n  = DIV_N_W'({r_grav, 16'b0});
                            div_d  = DIV_D_W'(r_hover);
                            n_step = STEP_SEED;
                        end
                    end
                end
            end
            S_WALK: begin
                // The queue memory reads the head entry every cycle.
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (age > 32'(r_wmax)) begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                    n_state = S_WALK;
                end else if (age < 32'(r_wmin)) begin
                    n_status = ST_RECENT;
                    n_state  = S_OUT;
                end else begin
                    n_head   = head_inc;
                    n_count  = r_count - 1'b1;
                    n_status = ST_UPDATED;
                    n_tneg   = r_mem_q.thr[19];
                    n_at     = r_mem_q.thr[19] ? 20'(-r_mem_q.thr) : r_mem_q.thr;
                    if (r_fac == '0) begin
                        n_state = S_OUT;
                    end else begin
                        mul_go = 1'b1;
                        mul_a  = MUL_A_W'(n_at);
                        mul_b  = MUL_B_W'(n_at);
                        n_step = STEP_M1;
                    end
                end
            end
            S_MUL: begin
                n_mp  = {r_mp[MUL_P_W-2:0], 1'b0} +
                        (r_mb[MUL_B_W-1] ? MUL_P_W'(r_ma) : '0);
                n_mb  = {r_mb[MUL_B_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_POST;
            end
            S_DIV: begin
                n_dr  = div_ge ? div_t - {1'b0, r_dd} : div_t;
                n_dq  = {r_dq[DIV_N_W-2:0], div_ge};
                n_dn  = {r_dn[DIV_N_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_POST;
            end
            S_POST: begin
                case (r_step)
                    STEP_CMD: begin
                        qmag = (r_dq > DIV_N_W'(524288)) ? 20'h80000 : r_dq[19:0];
                        if (r_acc[31]) push_thr = 20'(-qmag);
                        else push_thr = qmag[19] ? THR_MAX : qmag;
                        push_en  = 1'b1;
                        n_thr    = push_thr;
                        n_status = ST_THROTTLE;
                        n_state  = S_OUT;
                    end
                    STEP_SEED: begin
                        n_gain  = (r_dq[DIV_N_W-1:32] != '0) ? '1 : r_dq[31:0];
                        n_state = S_OUT;
                    end
                    STEP_M1: begin
                        mul_go = 1'b1;
                        mul_a  = MUL_A_W'(r_mp[38:0]);
                        mul_b  = r_cov;
                        n_step = STEP_M2;
                    end
                    STEP_M2: begin
                        // Denominator: forgetting factor plus thr^2 * P, in Q.24.
                        n_d    = 64'({r_fac, 8'b0}) + 64'(r_mp[86:32]);
                        mul_go = 1'b1;
                        mul_a  = MUL_A_W'(r_cov);
                        mul_b  = MUL_B_W'(r_at);
                        n_step = STEP_M3;
                    end
                    STEP_M3: begin
                        div_go = 1'b1;
                        div_n  = DIV_N_W'({r_mp[67:0], 8'b0});
                        div_d  = r_d;
                        n_step = STEP_D1;
                    end
                    STEP_D1: begin
                        n_k    = (r_dq[DIV_N_W-1:64] != '0) ? '1 : r_dq[63:0];
                        mul_go = 1'b1;
                        mul_a  = MUL_A_W'(r_at);
                        mul_b  = MUL_B_W'(r_gain);
                        n_step = STEP_M4;
                    end
                    STEP_M4: begin
                        s_prod = {2'b0, r_mp[51:16]};
                        if (r_tneg) s_prod = -s_prod;
                        err    = {{6{r_acc[31]}}, r_acc} - s_prod;
                        n_eneg = err[37];
                        ae_mag = err[37] ? 37'(-err) : err[36:0];
                        mul_go = 1'b1;
                        mul_a  = r_k;
                        mul_b  = MUL_B_W'(ae_mag);
                        n_step = STEP_M5;
                    end
                    STEP_M5: begin
                        dlt_raw = r_mp[111:24];
                        delta   = (dlt_raw > 88'h100_0000_0000) ? 41'h100_0000_0000 :
                                  dlt_raw[40:0];
                        if (r_tneg != r_eneg) ng = {11'b0, r_gain} - {2'b0, delta};
                        else ng = {11'b0, r_gain} + {2'b0, delta};
                        if (ng[42]) n_gain = '0;
                        else if (ng[41:32] != '0) n_gain = '1;
                        else n_gain = ng[31:0];
                        div_go = 1'b1;
                        div_n  = DIV_N_W'({r_fac, 32'b0});
                        div_d  = r_d;
                        n_step = STEP_D2;
                    end
                    STEP_D2: begin
                        mul_go = 1'b1;
                        mul_a  = MUL_A_W'(r_dq[24:0]);
                        mul_b  = r_cov;
                        n_step = STEP_M6;
                    end
                    STEP_M6: begin
                        div_go = 1'b1;
                        div_n  = DIV_N_W'({r_mp[71:24], 16'b0});
                        div_d  = DIV_D_W'(r_fac);
                        n_step = STEP_D3;
                    end
                    STEP_D3: begin
                        n_cov   = (r_dq[DIV_N_W-1:48] != '0) ? COV_MAX : r_dq[47:0];
                        n_state = S_OUT;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_OUT: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_othr  = r_thr;
                    n_ost   = r_status;
                    n_ogain = n_gain;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (mul_go) begin
            n_ma = mul_a;  n_mb = mul_b;  n_mp = '0;
            n_cnt = MUL_LAST;  n_state = S_MUL;
        end
        if (div_go) begin
            n_dn = div_n;  n_dd = div_d;  n_dr = '0;  n_dq = '0;
            n_cnt = DIV_LAST;  n_state = S_DIV;
        end

        // A push into a full queue overwrites the oldest entry at the head.
        if (push_en) begin
            w_we = 1'b1;
            w_wd = '{stamp: n_now, thr: push_thr};
            if (32'(r_count) >= QUEUE_DEPTH) begin
                w_wa   = r_head;
                n_head = head_inc;
            end else begin
                slot_sum = (QA_W+1)'(r_head) + (QA_W+1)'(r_count);
                if (32'(slot_sum) >= QUEUE_DEPTH)
                    slot_sum = slot_sum - (QA_W+1)'(QUEUE_DEPTH);
                w_wa    = slot_sum[QA_W-1:0];
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_mem_q <= r_mem[n_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fac   <= RST_FAC;
            r_grav  <= RST_GRAV;
            r_hover <= RST_HOVER;
            r_wmin  <= RST_WMIN;
            r_wmax  <= RST_WMAX;
            r_head  <= '0;
            r_count <= '0;
            r_gain  <= GAIN_INIT;
            r_cov   <= COV_INIT;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fac   <= n_fac;
            r_grav  <= n_grav;
            r_hover <= n_hover;
            r_wmin  <= n_wmin;
            r_wmax  <= n_wmax;
            r_head  <= n_head;
            r_count <= n_count;
            r_gain  <= n_gain;
            r_cov   <= n_cov;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;  r_acc <= n_acc;  r_now <= n_now;
        r_at <= n_at;  r_thr <= n_thr;  r_tneg <= n_tneg;  r_eneg <= n_eneg;
        r_d <= n_d;  r_k <= n_k;  r_status <= n_status;
        r_ma <= n_ma;  r_mb <= n_mb;  r_mp <= n_mp;
        r_dn <= n_dn;  r_dd <= n_dd;  r_dr <= n_dr;  r_dq <= n_dq;  r_cnt <= n_cnt;
        r_othr <= n_othr;  r_ost <= n_ost;  r_ogain <= n_ogain;
    end

endmodule
